// ===== rtl/ilss_pkg.sv =====
// Package for the integer list sort and stats core.
// Holds request and status codes shared by the core, divider, checker and testbench; no dependencies.
`timescale 1ns / 1ps
package ilss_pkg;
	localparam logic [2:0] REQ_ADD   = 3'd0;
	localparam logic [2:0] REQ_CLEAR = 3'd1;
	localparam logic [2:0] REQ_SORTA = 3'd2;
	localparam logic [2:0] REQ_SORTD = 3'd3;
	localparam logic [2:0] REQ_COUNT = 3'd4;
	localparam logic [2:0] REQ_STATS = 3'd5;
	localparam logic [2:0] REQ_PRINT = 3'd6;
	// Reserved code; the core takes it and produces nothing.
	localparam logic [2:0] REQ_RSVD  = 3'd7;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// Control from the sequencer to the mean divider.
	typedef struct packed {
		logic        start;
		logic [47:0] dividend;
		logic [6:0]  divisor;
	} ilss_div_req_t;
endpackage

// ===== rtl/ilss_ram.sv =====
// Simple dual-port list memory with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
module ilss_ram #(
	parameter int DEPTH = 32,
	parameter int AW = 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);
	logic [31:0] mem [DEPTH];

	// One write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/ilss_div.sv =====
// Restoring signed divider for the mean, one quotient bit per cycle.
// Depends on ilss_pkg.
`timescale 1ns / 1ps
module ilss_div import ilss_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  ilss_div_req_t req,
	output logic          done,
	output logic [39:0]   quot
);
	logic [47:0] mag_q;
	logic [7:0]  rem_q;
	logic        neg_q;
	logic [6:0]  den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [7:0]  trial;
	logic [47:0] qfull;

	assign trial = {rem_q[6:0], mag_q[47]};
	assign qfull = neg_q ? (48'd0 - mag_q) : mag_q;

	// Shift in one dividend bit, subtract when it fits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				neg_q  <= req.dividend[47];
				mag_q  <= req.dividend[47] ? (48'd0 - req.dividend) : req.dividend;
				rem_q  <= '0;
				den_q  <= req.divisor;
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				if (trial >= {1'b0, den_q}) begin
					rem_q <= trial - {1'b0, den_q};
					mag_q <= {mag_q[46:0], 1'b1};
				end else begin
					rem_q <= trial;
					mag_q <= {mag_q[46:0], 1'b0};
				end
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd47) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign quot = qfull[39:0];
endmodule

// ===== rtl/integer_list_sort_and_stats_core.sv =====
// Integer list sort and stats core: list memory, sequencer, mean divider.
// Add, clear and empty queries go straight to the result; count and stats first scan the list,
// print returns one result per element, and stats then waits on the 48-step divider.
// Sort: n - 1 bubble passes over the list (a swap costs one more S_SRTB step), then the result.
// A new request is taken the cycle after the last result leaves.
// Reset empties the list; memory contents are not cleared.
`timescale 1ns / 1ps
module integer_list_sort_and_stats_core import ilss_pkg::*; #(
	parameter int LIST_DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         req_type,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic signed [31:0] element,
	output logic signed [31:0] largest,
	output logic [6:0]         tally,
	output logic signed [39:0] mean_q8,
	output logic               last
);
	localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_WAITA, S_SRTB, S_SRTW, S_SCAN, S_DIV, S_PRN, S_EMIT
	} state_t;

	state_t      state_q;
	logic [2:0]  req_q;
	logic [31:0] key_q;
	logic [6:0]  n_q;
	logic [6:0]  idx_q;
	logic [6:0]  pass_q;
	logic [6:0]  cnt_q;
	logic [31:0] mn_q, mx_q, a_q;
	logic [47:0] sum_q;
	logic        swap_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [31:0]   wdata, rdata;
	ilss_div_req_t dreq;
	logic          ddone;
	logic [39:0]   dquot;
	logic          accept, out_free, emit;
	logic [6:0]    idx_nx;
	logic          pass_end;
	logic [47:0]   sum_nx;

	ilss_ram #(.DEPTH(LIST_DEPTH), .AW(AW)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);
	ilss_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .done(ddone), .quot(dquot));

	// A new request waits until the previous result transaction has left.
	assign in_stall = (state_q != S_IDLE) || out_valid;
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	assign emit     = out_free && (state_q == S_EMIT || state_q == S_PRN);
	assign idx_nx   = idx_q + 7'd1;
	assign pass_end = (idx_nx == n_q);
	assign sum_nx   = sum_q + {{16{rdata[31]}}, rdata};

	// Memory port control: appends in idle, swap writes in sort.
	always_comb begin
		we    = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = a_q;
		raddr = idx_q[AW-1:0];
		if (accept && req_type == REQ_ADD && n_q < 7'(LIST_DEPTH)) begin
			we    = 1'b1;
			waddr = n_q[AW-1:0];
			wdata = value;
		end else if (state_q == S_SRTW) begin
			we    = swap_q;
			waddr = idx_q[AW-1:0] - AW'(1);
			wdata = rdata;
			raddr = idx_q[AW-1:0] + AW'(1);
		end else if (state_q == S_SRTB && swap_q) begin
			we    = 1'b1;
			wdata = a_q;
			raddr = idx_q[AW-1:0] + AW'(1);
		end else if (state_q == S_PRN) begin
			// Keep the element on the read port while the result waits.
			raddr = idx_q[AW-1:0] - AW'(1);
		end
	end

	// The dividend includes the last element, which is summed in the same cycle.
	always_comb begin
		dreq.start    = (state_q == S_SCAN) && (idx_q == n_q) && out_free;
		dreq.dividend = {sum_nx[39:0], 8'd0};
		dreq.divisor  = n_q;
	end

	// Request sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			n_q       <= '0;
			out_valid <= 1'b0;
			swap_q    <= 1'b0;
		end else begin
			out_valid <= emit || (out_valid && out_stall);
			case (state_q)
				S_IDLE: begin
					swap_q <= 1'b0;
					if (accept && req_type != REQ_RSVD) begin
						req_q   <= req_type;
						key_q   <= value;
						idx_q   <= '0;
						pass_q  <= 7'd1;
						cnt_q   <= '0;
						sum_q   <= '0;
						largest <= '0;
						mean_q8 <= '0;
						last    <= 1'b1;
						element <= (req_type == REQ_ADD) ? value : 32'sd0;
						if (req_type == REQ_ADD) begin
							if (n_q < 7'(LIST_DEPTH)) begin
								n_q    <= n_q + 7'd1;
								tally  <= n_q + 7'd1;
								status <= ST_OK;
							end else begin
								tally  <= n_q;
								status <= ST_FULL;
							end
							state_q <= S_EMIT;
						end else if (req_type == REQ_CLEAR) begin
							n_q     <= '0;
							tally   <= '0;
							status  <= ST_OK;
							state_q <= S_EMIT;
						end else if (n_q == 7'd0) begin
							tally   <= n_q;
							status  <= ST_EMPTY;
							state_q <= S_EMIT;
						end else begin
							tally  <= n_q;
							status <= ST_OK;
							if ((req_type == REQ_SORTA || req_type == REQ_SORTD)
									&& n_q == 7'd1) begin
								state_q <= S_EMIT;
							end else begin
								state_q <= S_RD;
							end
						end
					end
				end
				S_RD: begin
					// Address idx_q issued; data arrives next cycle.
					idx_q <= idx_nx;
					if (req_q == REQ_SORTA || req_q == REQ_SORTD) state_q <= S_WAITA;
					else state_q <= (req_q == REQ_PRINT) ? S_PRN : S_SCAN;
				end
				S_WAITA: begin
					a_q <= rdata;
					state_q <= S_SRTB;
				end
				S_SRTB: begin
					// rdata is entry idx_q; a_q holds entry idx_q-1.
					if (swap_q) begin
						// a_q now sits at idx_q and stays the left partner.
						swap_q <= 1'b0;
						idx_q  <= pass_end ? 7'd0 : idx_nx;
						if (pass_end) begin
							if (pass_q + 7'd1 == n_q) begin
								tally <= n_q;
								state_q <= S_EMIT;
							end else begin
								pass_q <= pass_q + 7'd1;
								state_q <= S_RD;
							end
						end else begin
							state_q <= S_SRTB;
						end
					end else begin
						swap_q <= (req_q == REQ_SORTD) ? ($signed(a_q) < $signed(rdata))
							: ($signed(a_q) > $signed(rdata));
						state_q <= S_SRTW;
					end
				end
				S_SRTW: begin
					// On a swap, write the right partner into the lower slot.
					if (swap_q) begin
						state_q <= S_SRTB;
					end else begin
						idx_q <= pass_end ? 7'd0 : idx_nx;
						if (pass_end) begin
							if (pass_q + 7'd1 == n_q) begin
								tally <= n_q;
								state_q <= S_EMIT;
							end else begin
								pass_q <= pass_q + 7'd1;
								state_q <= S_RD;
							end
						end else begin
							a_q <= rdata;
							state_q <= S_SRTB;
						end
					end
				end
				S_SCAN: begin
					if (idx_q == n_q) begin
						if (out_free) begin
							if (req_q == REQ_COUNT) begin
								tally <= cnt_q + ((rdata == key_q) ? 7'd1 : 7'd0);
								state_q <= S_EMIT;
							end else begin
								tally <= n_q;
								state_q <= S_DIV;
							end
						end
					end else begin
						idx_q <= idx_nx;
					end
					if (!(idx_q == n_q && !out_free)) begin
						if (rdata == key_q) cnt_q <= cnt_q + 7'd1;
						sum_q <= sum_nx;
						if (idx_q == 7'd1 || $signed(rdata) < $signed(mn_q)) mn_q <= rdata;
						if (idx_q == 7'd1 || $signed(rdata) > $signed(mx_q)) mx_q <= rdata;
					end
				end
				S_DIV: begin
					if (ddone) begin
						element <= mn_q; largest <= mx_q; mean_q8 <= dquot;
						state_q <= S_EMIT;
					end
				end
				S_PRN: begin
					if (out_free) begin
						element <= rdata;
						last <= (idx_q == n_q);
						if (idx_q == n_q) state_q <= S_IDLE;
						else state_q <= S_RD;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/ilss_chk.sv =====
// Port checker for the integer list sort and stats core, with its bind.
// Depends on ilss_pkg and the top level's ports.
`timescale 1ns / 1ps
module ilss_chk import ilss_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [2:0] req_type,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] status,
	input logic [6:0] tally,
	input logic       last
);
	// A stalled result transaction holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(tally))
		else $error("stalled result changed");
	// No status code beyond list full.
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_FULL) else $error("bad status");
	// An empty status is always a single final result.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> last && tally == 7'd0)
		else $error("empty result malformed");
	// The core is busy right after taking a known request.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && req_type != REQ_RSVD |=> in_stall || out_valid)
		else $error("request not taken");
endmodule

bind integer_list_sort_and_stats_core ilss_chk u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.req_type(req_type), .out_valid(out_valid), .out_stall(out_stall), .status(status),
	.tally(tally), .last(last)
);

// ===== tb/sv/tb_integer_list_sort_and_stats_core.sv =====
// Testbench for the integer list sort and stats core.
// Drives list requests with random pacing and checks every result against a built-in
// list predictor; depends on ilss_pkg and integer_list_sort_and_stats_core.
`timescale 1ns / 1ps

// Expected result of one list request.
typedef struct {
	logic [1:0]         status;
	logic signed [31:0] element;
	logic signed [31:0] largest;
	logic [6:0]         tally;
	logic signed [39:0] mean_q8;
	logic               last;
} list_result_t;

// Scoreboard: mirrors the list contents and keeps the queue of pending results.
class list_scoreboard;
	int                 depth;
	logic signed [31:0] entries[$];
	list_result_t       pending[$];
	int                 errors;

	function new(int d);
		depth = d;
		errors = 0;
	endfunction

	function void push(logic [1:0] st, logic signed [31:0] el, logic signed [31:0] mx,
			logic [6:0] ta, logic signed [39:0] mq, logic la);
		list_result_t r;
		r.status = st;
		r.element = el;
		r.largest = mx;
		r.tally = ta;
		r.mean_q8 = mq;
		r.last = la;
		pending = {pending, r};
	endfunction

	// Apply one accepted request to the list and queue the results it causes.
	function void note_request(logic [2:0] req, logic signed [31:0] val);
		int n;
		int cnt;
		logic signed [31:0] mn;
		logic signed [31:0] mx;
		logic signed [31:0] t;
		longint sum;
		longint mean;
		n = entries.size();
		if (req == ilss_pkg::REQ_ADD) begin
			if (n >= depth) begin
				push(ilss_pkg::ST_FULL, val, 0, 7'(n), 0, 1);
			end else begin
				entries = {entries, val};
				push(ilss_pkg::ST_OK, val, 0, 7'(n + 1), 0, 1);
			end
		end else if (req == ilss_pkg::REQ_CLEAR) begin
			entries.delete();
			push(ilss_pkg::ST_OK, 0, 0, 0, 0, 1);
		end else if (req > ilss_pkg::REQ_PRINT) begin
			// Unknown request codes are ignored by the block.
		end else if (n == 0) begin
			push(ilss_pkg::ST_EMPTY, 0, 0, 0, 0, 1);
		end else if (req == ilss_pkg::REQ_SORTA || req == ilss_pkg::REQ_SORTD) begin
			// Full bubble passes; the final order is a plain sort either way.
			for (int p = 0; p + 1 < n; p++) begin
				for (int j = 0; j + 1 < n; j++) begin
					if (req == ilss_pkg::REQ_SORTD ? entries[j] < entries[j + 1]
							: entries[j] > entries[j + 1]) begin
						t = entries[j];
						entries[j] = entries[j + 1];
						entries[j + 1] = t;
					end
				end
			end
			push(ilss_pkg::ST_OK, 0, 0, 7'(n), 0, 1);
		end else if (req == ilss_pkg::REQ_COUNT) begin
			cnt = 0;
			foreach (entries[i]) if (entries[i] == val) cnt++;
			push(ilss_pkg::ST_OK, 0, 0, 7'(cnt), 0, 1);
		end else if (req == ilss_pkg::REQ_STATS) begin
			mn = entries[0];
			mx = entries[0];
			sum = 0;
			foreach (entries[i]) begin
				if (entries[i] < mn) mn = entries[i];
				if (entries[i] > mx) mx = entries[i];
				sum += entries[i];
			end
			// SystemVerilog division truncates toward zero.
			mean = (sum * 256) / n;
			push(ilss_pkg::ST_OK, mn, mx, 7'(n), mean[39:0], 1);
		end else begin
			foreach (entries[i]) push(ilss_pkg::ST_OK, entries[i], 0, 7'(n), 0, i + 1 == n);
		end
	endfunction

	task report_mismatch(string msg);
		errors++;
		$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	// Compare one accepted result with the oldest expectation.
	task check_result(list_result_t got);
		list_result_t want;
		if (pending.size() == 0) begin
			report_mismatch("result with nothing expected");
			return;
		end
		want = pending.pop_front();
		if (got.status !== want.status) report_mismatch($sformatf("status %0d want %0d",
			got.status, want.status));
		if (got.element !== want.element) report_mismatch($sformatf("element %0d want %0d",
			got.element, want.element));
		if (got.largest !== want.largest) report_mismatch($sformatf("largest %0d want %0d",
			got.largest, want.largest));
		if (got.tally !== want.tally) report_mismatch($sformatf("tally %0d want %0d",
			got.tally, want.tally));
		if (got.mean_q8 !== want.mean_q8) report_mismatch($sformatf("mean_q8 %0d want %0d",
			got.mean_q8, want.mean_q8));
		if (got.last !== want.last) report_mismatch($sformatf("last %0d want %0d",
			got.last, want.last));
	endtask
endclass

module tb_integer_list_sort_and_stats_core;
	import ilss_pkg::*;

	localparam int DEPTH = 32;
	localparam int WATCHDOG_LIMIT = 200000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         req_type;
	logic signed [31:0] value;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         status;
	logic signed [31:0] element;
	logic signed [31:0] largest;
	logic [6:0]         tally;
	logic signed [39:0] mean_q8;
	logic               last;

	list_scoreboard board;
	bit             hold_off;
	bit             sending_done;
	int             idle_cycles;

	integer_list_sort_and_stats_core #(.LIST_DEPTH(DEPTH)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .req_type(req_type), .value(value),
		.out_valid(out_valid), .out_stall(out_stall), .status(status), .element(element),
		.largest(largest), .tally(tally), .mean_q8(mean_q8), .last(last)
	);

	// Clock with a 10 ns period.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Random value that favors the extremes and a few small keys for counts.
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'sh7FFFFFFF - $urandom_range(0, 2);
			1: return 32'sh80000000 + $urandom_range(0, 2);
			2: return $urandom_range(0, 6) - 3;
			default: return $urandom;
		endcase
	endfunction

	// Offer one request and hold it until the block accepts it.
	task send_request(logic [2:0] req, logic signed [31:0] val);
		in_valid <= 1'b1;
		req_type <= req;
		value <= val;
		do @(posedge clk); while (in_stall);
		board.note_request(req, val);
		@(negedge clk);
	endtask

	task send_gap();
		in_valid <= 1'b0;
		repeat ($urandom_range(1, 4)) @(negedge clk);
	endtask

	// Weighted random request: mostly adds so the list fills and exercises full.
	task send_random();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) send_request(REQ_ADD, pick_value());
		else if (r < 55) send_request(REQ_CLEAR, 0);
		else if (r < 62) send_request(REQ_SORTA, $urandom);
		else if (r < 69) send_request(REQ_SORTD, $urandom);
		else if (r < 78) send_request(REQ_COUNT, pick_value());
		else if (r < 87) send_request(REQ_STATS, $urandom);
		else if (r < 96) send_request(REQ_PRINT, $urandom);
		else send_request(REQ_RSVD, $urandom);
	endtask

	// Stimulus: reset, directed cases, then random bursts.
	initial begin
		int burst;
		board = new(DEPTH);
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_ADD;
		value = 0;
		sending_done = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		// Empty list queries, then extremes, duplicates and every request.
		send_request(REQ_SORTA, 0);
		send_request(REQ_SORTD, 0);
		send_request(REQ_COUNT, 0);
		send_request(REQ_STATS, 0);
		send_request(REQ_PRINT, 0);
		send_request(REQ_ADD, 32'sh7FFFFFFF);
		send_request(REQ_ADD, 32'sh80000000);
		send_request(REQ_ADD, -1);
		send_request(REQ_ADD, -1);
		send_request(REQ_STATS, 0);
		send_request(REQ_COUNT, -1);
		send_request(REQ_SORTA, 0);
		send_request(REQ_PRINT, 0);
		send_request(REQ_SORTD, 0);
		send_request(REQ_PRINT, 0);
		send_request(REQ_RSVD, 5);
		send_request(REQ_CLEAR, 0);
		send_request(REQ_STATS, 0);
		// Fill past capacity with negatives to check full and a negative mean.
		for (int i = 0; i < DEPTH + 2; i++) send_request(REQ_ADD, -3 - i);
		send_request(REQ_STATS, 0);
		send_request(REQ_CLEAR, 0);
		// Random bursts separated by gaps.
		for (int k = 0; k < 170; k += burst) begin
			burst = $urandom_range(1, 12);
			for (int i = 0; i < burst; i++) send_random();
			send_gap();
		end
		in_valid <= 1'b0;
		sending_done = 1;
	end

	// Receiver stall pattern, with one long hold-off early in the run.
	initial begin
		out_stall = 1'b0;
		hold_off = 0;
		wait (arst_n);
		repeat (60) @(negedge clk);
		out_stall <= 1'b1;
		hold_off = 1;
		repeat (400) @(negedge clk);
		hold_off = 0;
		forever begin
			@(negedge clk);
			case ($urandom_range(0, 3))
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= $urandom_range(0, 1);
			endcase
		end
	end

	// Result sampling and checking at the rising edge.
	always @(posedge clk) begin
		list_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.status = status;
			got.element = element;
			got.largest = largest;
			got.tally = tally;
			got.mean_q8 = mean_q8;
			got.last = last;
			board.check_result(got);
		end
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || hold_off)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// End of run: drain, let the block settle, then give the verdict.
	initial begin
		idle_cycles = 0;
		wait (sending_done);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
